FILE: rtl/ira_pkg.sv
// ============================================================================
// ID range allocator package
// Shared item types, function codes and sizing constants.
// ============================================================================
package ira_pkg;

    // Default size of the ID table
    localparam int ID_COUNT_DEF = 256;
    // Widest occupancy row, the unit of the scan
    localparam int ROW_W_MAX = 32;

    localparam logic [1:0] FUNC_ALLOC_LOWEST = 2'd0;
    localparam logic [1:0] FUNC_ALLOC_CYCLIC = 2'd1;
    localparam logic [1:0] FUNC_FREE = 2'd2;
    localparam logic [1:0] FUNC_FIND = 2'd3;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] ext_id;
        logic [8:0]  low_bound;
        logic [8:0]  high_bound;
        logic [31:0] data_in;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [31:0] id_out;
        logic [31:0] data_out;
    } t_result;

endpackage

FILE: rtl/ira_ram.sv
// ============================================================================
// Generic RAM
// One write port, one read port, read data registered.
// ============================================================================
module ira_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/id_range_allocator_top.sv
// ============================================================================
// ID range allocator, top level
// Lowest-free and cyclic ID allocation with attached data words, free, find.
// ============================================================================
// Sequence: free/find read the bitmap and data word, then strobe o_done; an ID
//   outside the table fails at once. Alloc sets up the range, then scans the
//   occupancy rows in order; a cyclic alloc that wraps scans again from the low bound.
// Throughput: one item at a time; the row scan (up to 32 IDs a cycle) sets it.
// Reset: a clearing pass over the occupancy rows (8 at 256 IDs) holds busy
//   high; offset and cursor reset to zero. Results cannot be stalled.
// ============================================================================
module id_range_allocator_top #(
    parameter int ID_COUNT = ira_pkg::ID_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  ira_pkg::t_item   i_item,
    // result channel
    output logic             o_done,
    output ira_pkg::t_result o_result,
    // offset register
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata
);

    // Row geometry: rows are a power of two wide so row/column are bit fields
    localparam int RW = (ID_COUNT >= ira_pkg::ROW_W_MAX) ? ira_pkg::ROW_W_MAX
                                                          : 2 ** $clog2(ID_COUNT);
    localparam int RB = $clog2(RW);
    localparam int ROWS = (ID_COUNT + RW - 1) / RW;
    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW = AW + RB;                  // row and column of a hit
    localparam int DA = $clog2(ID_COUNT);         // data RAM address
    localparam int IW = $clog2(ID_COUNT + 1);     // cursor, may equal ID_COUNT
    localparam int CW = (IW > 9) ? IW : 9;        // bound arithmetic

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_LOOK,
        S_LOOK_CHK
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr;
    logic [31:0]      r_offset;
    logic [IW-1:0]    r_cursor;
    logic [1:0]       r_func;
    logic [31:0]      r_ext;
    logic [31:0]      r_din;
    logic [CW-1:0]    r_from;
    logic [CW-1:0]    r_to;
    logic [CW-1:0]    r_lo1;
    logic             r_pass;
    logic [AW-1:0]    r_first_row;
    logic [RB-1:0]    r_first_col;
    logic [AW-1:0]    r_last_row;
    logic [RB-1:0]    r_last_col;
    logic [AW-1:0]    r_chk_row;
    logic [DA-1:0]    r_id;
    logic             r_done;
    ira_pkg::t_result r_out;

    // RAM ports
    logic             bm_we;
    logic [AW-1:0]    bm_waddr;
    logic [RW-1:0]    bm_wdata;
    logic             bm_re;
    logic [AW-1:0]    bm_raddr;
    logic [RW-1:0]    bm_rdata;
    logic             dm_we;
    logic [DA-1:0]    dm_waddr;
    logic [31:0]      dm_rdata;

    // Accept-time decode
    logic             accept;
    logic [31:0]      look_id;
    logic             look_in_range;
    logic [CW-1:0]    lo_c;
    logic [CW-1:0]    hi_c;
    logic [CW-1:0]    lo1;
    logic [CW-1:0]    hi1;
    logic [CW-1:0]    st_a;
    logic [CW-1:0]    st_b;
    logic [CW-1:0]    st1;

    // Scan
    logic             rng_empty;
    logic [CW-1:0]    last_idx;
    logic [AW-1:0]    first_row;
    logic [AW-1:0]    last_row;
    logic [RW-1:0]    free_v;
    logic             hit;
    logic [RB-1:0]    hit_col;
    logic [SW-1:0]    hit_id;
    logic             at_last;
    logic             look_bit;

    assign busy = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_done = r_done;
    assign o_result = r_out;

    // Free/find: take the offset back off and check the table size
    assign look_id = i_item.ext_id - r_offset;
    assign look_in_range = (look_id < 32'(ID_COUNT));

    // Allocation bounds: raise low to 1, saturate high to the table size,
    // clamp the cursor into [low, high] for a cyclic start
    always_comb begin
        lo_c = CW'(i_item.low_bound);
        hi_c = CW'(i_item.high_bound);
        lo1 = (lo_c == '0) ? CW'(1) : lo_c;
        hi1 = (hi_c > CW'(ID_COUNT)) ? CW'(ID_COUNT) : hi_c;
        st_a = (CW'(r_cursor) < lo_c) ? lo_c : CW'(r_cursor);
        st_b = (st_a > hi_c) ? hi_c : st_a;
        st1 = (st_b == '0) ? CW'(1) : st_b;
    end

    // Range of the current pass in rows and columns
    assign rng_empty = (r_from >= r_to);
    assign last_idx = r_to - CW'(1);
    assign first_row = AW'(r_from >> RB);
    assign last_row = AW'(last_idx >> RB);

    // Free IDs of the row on the read port, masked to the range
    always_comb begin
        for (int j = 0; j < RW; j++) begin
            free_v[j] = !bm_rdata[j]
                        && ((r_chk_row != r_first_row) || (RB'(j) >= r_first_col))
                        && ((r_chk_row != r_last_row) || (RB'(j) <= r_last_col));
        end
        hit = 1'b0;
        hit_col = '0;
        for (int j = RW - 1; j >= 0; j--) begin
            if (free_v[j]) begin
                hit = 1'b1;
                hit_col = RB'(j);
            end
        end
    end

    assign hit_id = {r_chk_row, hit_col};
    assign at_last = (r_chk_row == r_last_row);
    assign look_bit = bm_rdata[r_id[RB-1:0]];

    // RAM port control
    always_comb begin
        bm_we = 1'b0;
        bm_waddr = r_chk_row;
        bm_wdata = bm_rdata;
        bm_re = 1'b0;
        bm_raddr = r_chk_row + AW'(1);
        dm_we = 1'b0;
        dm_waddr = DA'(hit_id);
        case (r_state)
            S_CLEAR: begin
                bm_we = 1'b1;
                bm_waddr = r_clr;
                bm_wdata = '0;
            end
            S_START: begin
                bm_re = 1'b1;
                bm_raddr = first_row;
            end
            S_SCAN: begin
                // Prefetch the next row while checking this one
                bm_re = 1'b1;
                if (hit) begin
                    bm_we = 1'b1;
                    bm_wdata = bm_rdata | (RW'(1) << hit_col);
                    dm_we = 1'b1;
                end
            end
            S_LOOK: begin
                bm_re = 1'b1;
                bm_raddr = AW'(r_id >> RB);
            end
            S_LOOK_CHK: begin
                // Release the ID when freeing an occupied entry
                if (look_bit && (r_func == ira_pkg::FUNC_FREE)) begin
                    bm_we = 1'b1;
                    bm_waddr = AW'(r_id >> RB);
                    bm_wdata = bm_rdata & ~(RW'(1) << r_id[RB-1:0]);
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_offset <= '0;
            r_cursor <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_func <= i_item.func;
                        r_ext <= i_item.ext_id;
                        r_din <= i_item.data_in;
                        r_id <= look_id[DA-1:0];
                        r_lo1 <= lo1;
                        r_to <= hi1;
                        case (i_item.func)
                            ira_pkg::FUNC_ALLOC_LOWEST: begin
                                r_from <= lo1;
                                r_pass <= 1'b1;
                                r_state <= S_START;
                            end
                            ira_pkg::FUNC_ALLOC_CYCLIC: begin
                                r_from <= st1;
                                r_pass <= 1'b0;
                                r_state <= S_START;
                            end
                            default: begin
                                if (look_in_range) begin
                                    r_state <= S_LOOK;
                                end else begin
                                    // Outside the table: fail at once
                                    r_out <= '{status: ira_pkg::STATUS_FAIL,
                                               id_out: i_item.ext_id,
                                               data_out: '0};
                                    r_done <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_START: begin
                    r_first_row <= first_row;
                    r_first_col <= r_from[RB-1:0];
                    r_last_row <= last_row;
                    r_last_col <= last_idx[RB-1:0];
                    r_chk_row <= first_row;
                    if (!rng_empty) begin
                        r_state <= S_SCAN;
                    end else if (!r_pass) begin
                        // Cyclic wrap: search again from the low bound
                        r_from <= r_lo1;
                        r_pass <= 1'b1;
                    end else begin
                        r_out <= '{status: ira_pkg::STATUS_FAIL, id_out: '0,
                                   data_out: '0};
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (r_func == ira_pkg::FUNC_ALLOC_CYCLIC) begin
                            r_cursor <= IW'(hit_id) + IW'(1);
                        end
                        r_out <= '{status: ira_pkg::STATUS_OK,
                                   id_out: r_offset + 32'(hit_id),
                                   data_out: '0};
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (at_last) begin
                        if (!r_pass) begin
                            r_from <= r_lo1;
                            r_pass <= 1'b1;
                            r_state <= S_START;
                        end else begin
                            r_out <= '{status: ira_pkg::STATUS_FAIL, id_out: '0,
                                       data_out: '0};
                            r_done <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_chk_row <= r_chk_row + AW'(1);
                    end
                end
                S_LOOK: begin
                    r_state <= S_LOOK_CHK;
                end
                S_LOOK_CHK: begin
                    r_out <= '{status: look_bit ? ira_pkg::STATUS_OK
                                                : ira_pkg::STATUS_FAIL,
                               id_out: r_ext,
                               data_out: look_bit ? dm_rdata : 32'd0};
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Occupancy bitmap, one row of RW IDs per entry
    ira_ram #(
        .WIDTH (RW),
        .DEPTH (ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    // Data words attached to IDs
    ira_ram #(
        .WIDTH (32),
        .DEPTH (ID_COUNT)
    ) u_data (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (r_din),
        .i_re    (r_state == S_LOOK),
        .i_raddr (r_id),
        .o_rdata (dm_rdata)
    );

endmodule

FILE: tb/tb_id_range_allocator_top.sv
// ============================================================================
// ID range allocator testbench
// Drives alloc, cyclic alloc, free and find commands through the start/busy
// handshake, predicts every result from a local copy of the ID table, cursor
// and offset, and checks each result item field by field as it appears.
// ============================================================================
module tb_id_range_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_IDS = ira_pkg::ID_COUNT_DEF;
    // Worst alloc: two full scans of 8 occupancy rows.
    localparam int SETTLE_CYCLES = 32;
    // Cycles with no item and no result before the run is declared hung.
    localparam int IDLE_LIMIT = 4000;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    ira_pkg::t_item   i_item = '0;
    logic             o_done;
    ira_pkg::t_result o_result;
    logic             i_cfg_we = 1'b0;
    logic [31:0]      i_cfg_wdata = '0;

    id_range_allocator_top #(
        .ID_COUNT(NUM_IDS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow of the allocator: occupancy, data words, cyclic cursor, offset
    // ------------------------------------------------------------------------
    bit          id_used [NUM_IDS];
    logic [31:0] id_word [NUM_IDS];
    int          cursor = 0;
    int          used_count = 0;
    logic [31:0] id_base = '0;

    ira_pkg::t_result outcome_q[$];
    int      n_errors = 0;
    int      idle_pct = 0;
    int      stall_cycles = 0;

    // Lowest free internal ID in [max(lo,1), min(hi,NUM_IDS)); NUM_IDS if none.
    function automatic int lowest_free(int lo, int hi);
        int k;
        if (lo < 1) lo = 1;
        if (hi > NUM_IDS) hi = NUM_IDS;
        for (k = lo; k < hi; k++) begin
            if (!id_used[k]) return k;
        end
        return NUM_IDS;
    endfunction

    // Work out the result of one accepted item and advance the shadow state.
    function automatic ira_pkg::t_result compute_outcome(ira_pkg::t_item it);
        ira_pkg::t_result r;
        int          id;
        int          from;
        logic [31:0] internal;
        r.status   = ira_pkg::STATUS_FAIL;
        r.id_out   = '0;
        r.data_out = '0;
        if (it.func == ira_pkg::FUNC_ALLOC_LOWEST
            || it.func == ira_pkg::FUNC_ALLOC_CYCLIC) begin
            if (it.func == ira_pkg::FUNC_ALLOC_LOWEST) begin
                id = lowest_free(it.low_bound, it.high_bound);
            end else begin
                // clamp the cursor into the range, search up, then wrap to low
                from = cursor;
                if (from < int'(it.low_bound)) from = it.low_bound;
                if (from > int'(it.high_bound)) from = it.high_bound;
                id = lowest_free(from, it.high_bound);
                if (id >= NUM_IDS) id = lowest_free(it.low_bound, it.high_bound);
            end
            if (id < NUM_IDS) begin
                id_used[id] = 1'b1;
                id_word[id] = it.data_in;
                used_count++;
                if (it.func == ira_pkg::FUNC_ALLOC_CYCLIC) cursor = id + 1;
                r.status = ira_pkg::STATUS_OK;
                r.id_out = id_base + 32'(id);
            end
        end else begin
            internal = it.ext_id - id_base;
            r.id_out = it.ext_id;
            if (internal < 32'(NUM_IDS)) begin
                if (id_used[internal]) begin
                    r.status   = ira_pkg::STATUS_OK;
                    r.data_out = id_word[internal];
                    if (it.func == ira_pkg::FUNC_FREE) begin
                        id_used[internal] = 1'b0;
                        used_count--;
                    end
                end
            end
        end
        return r;
    endfunction

    // External ID of some occupied entry, or a random word if the table is empty.
    function automatic logic [31:0] pick_used_ext();
        int s;
        int k;
        s = $urandom_range(NUM_IDS - 1);
        for (k = 0; k < NUM_IDS; k++) begin
            if (id_used[(s + k) % NUM_IDS]) return id_base + 32'((s + k) % NUM_IDS);
        end
        return $urandom();
    endfunction

    function automatic ira_pkg::t_item mk(logic [1:0] f, logic [31:0] ext, int lo,
                                          int hi, logic [31:0] din);
        ira_pkg::t_item it;
        it.func       = f;
        it.ext_id     = ext;
        it.low_bound  = 9'(lo);
        it.high_bound = 9'(hi);
        it.data_in    = din;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------------

    // Send one item. Start is left high after acceptance so back-to-back
    // items keep it asserted; a random gap lowers it before the item is driven.
    task automatic send_item(input ira_pkg::t_item it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        i_item <= it;
        // busy read here is its value before the edge: accepted when low
        do @(posedge i_clk); while (busy);
        outcome_q.push_back(compute_outcome(it));
    endtask

    // Drop start, let every pending result arrive, then give the block time
    // to go fully idle.
    task automatic settle();
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the offset register; call only while the block is idle.
    task automatic write_offset(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        id_base = value;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobed result pops the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        ira_pkg::t_result want;
        if (o_done === 1'b1) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with nothing pending: expected none, actual %p",
                         $time, o_result);
                n_errors++;
            end else begin
                want = outcome_q.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    n_errors++;
                end
                if (o_result.id_out !== want.id_out) begin
                    $display("%0t: id_out mismatch: expected %h actual %h",
                             $time, want.id_out, o_result.id_out);
                    n_errors++;
                end
                if (o_result.data_out !== want.data_out) begin
                    $display("%0t: data_out mismatch: expected %h actual %h",
                             $time, want.data_out, o_result.data_out);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither an item nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Bound extremes, ID zero, empty ranges, cyclic wrap, free/find hits and
    // misses, IDs outside the table. Offset is zero here.
    task automatic test_directed();
        idle_pct = 0;
        send_item(mk(ira_pkg::FUNC_FIND, 32'h0, 0, 0, 32'h0));     // ID zero never used
        send_item(mk(ira_pkg::FUNC_FREE, 32'h0, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_ALLOC_LOWEST, 32'h0, 0, 256, 32'hFFFF_FFFF)); // 1
        send_item(mk(ira_pkg::FUNC_ALLOC_LOWEST, 32'h0, 0, 0, 32'h1));     // empty
        send_item(mk(ira_pkg::FUNC_ALLOC_LOWEST, 32'h0, 256, 256, 32'h2)); // empty
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 9, 5, 32'h3));     // lo > hi
        send_item(mk(ira_pkg::FUNC_ALLOC_LOWEST, 32'h0, 255, 256, 32'h0)); // top ID
        send_item(mk(ira_pkg::FUNC_ALLOC_LOWEST, 32'h0, 255, 256, 32'h4)); // full
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 20, 23, 32'hA5A5_0014));
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 20, 23, 32'hA5A5_0015));
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 20, 23, 32'hA5A5_0016));
        send_item(mk(ira_pkg::FUNC_FREE, 32'd21, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 20, 23, 32'h5A5A_5A5A)); // 21
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 20, 23, 32'h6)); // range full
        send_item(mk(ira_pkg::FUNC_FIND, 32'd21, 511, 511, 32'h0));
        send_item(mk(ira_pkg::FUNC_FIND, 32'd255, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_FREE, 32'd255, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_FIND, 32'd255, 0, 0, 32'h0));   // freed: absent
        send_item(mk(ira_pkg::FUNC_FREE, 32'd1, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_FIND, 32'd256, 0, 0, 32'h0));   // outside table
        send_item(mk(ira_pkg::FUNC_FIND, 32'hFFFF_FFFF, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_ALLOC_CYCLIC, 32'h0, 0, 256, 32'h7)); // past 22
    endtask

    // Offset near the top of the 32-bit space so external IDs wrap through 0.
    task automatic test_offset_wrap();
        settle();
        write_offset(32'hFFFF_FFF8);
        send_item(mk(ira_pkg::FUNC_ALLOC_LOWEST, 32'h0, 8, 9, 32'hC0DE_0008)); // ext 0
        send_item(mk(ira_pkg::FUNC_FIND, 32'h0, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_FREE, 32'h0, 0, 0, 32'h0));
        send_item(mk(ira_pkg::FUNC_FIND, 32'hFFFF_FFF8, 0, 0, 32'h0)); // internal zero
        send_item(mk(ira_pkg::FUNC_FIND, 32'hFFFF_FFF7, 0, 0, 32'h0)); // below base
    endtask

    // Mostly well-formed traffic: allocs over small ranges or the whole table, frees
    // and finds of live IDs; the rest hits empty ranges, absent and out-of-table IDs.
    task automatic test_random(input int count, input int pct);
        ira_pkg::t_item it;
        int    n;
        int    lo;
        int    hi;
        int    alloc_pct;
        idle_pct = pct;
        for (n = 0; n < count; n++) begin
            it.ext_id     = $urandom();
            it.low_bound  = 9'($urandom_range(256));
            it.high_bound = 9'($urandom_range(256));
            it.data_in    = $urandom();
            // steer the fill level so both full and empty ranges occur
            alloc_pct = (used_count < 64) ? 60 : (used_count > 192) ? 30 : 45;
            if ($urandom_range(99) < alloc_pct) begin
                it.func = $urandom_range(1) ? ira_pkg::FUNC_ALLOC_CYCLIC
                                            : ira_pkg::FUNC_ALLOC_LOWEST;
                case ($urandom_range(9))
                    0: begin
                        it.low_bound  = 9'd0;
                        it.high_bound = 9'd256;
                    end
                    1: ; // fully random bounds, often empty
                    default: begin
                        lo = $urandom_range(250);
                        hi = lo + $urandom_range(1, 12);
                        if (hi > NUM_IDS) hi = NUM_IDS;
                        it.low_bound  = 9'(lo);
                        it.high_bound = 9'(hi);
                    end
                endcase
            end else begin
                it.func = $urandom_range(1) ? ira_pkg::FUNC_FREE : ira_pkg::FUNC_FIND;
                case ($urandom_range(7))
                    0: ; // random external ID
                    1: it.ext_id = id_base + 32'($urandom_range(300));
                    2: it.ext_id = id_base - 32'($urandom_range(1, 4));
                    default: it.ext_id = pick_used_ext();
                endcase
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the clearing pass after reset is done
        do @(posedge i_clk); while (busy);

        write_offset(32'h0);
        test_directed();
        test_offset_wrap();

        settle();
        write_offset(32'hFFFF_FFFF);
        test_random(700, 0);

        settle();
        write_offset(32'h8000_0000);
        test_random(600, 85);

        settle();
        write_offset($urandom());
        test_random(700, 26);

        settle();
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ira_pkg.sv
rtl/ira_ram.sv
rtl/id_range_allocator_top.sv
tb/tb_id_range_allocator_top.sv
